>>> hdl/tqcs_pkg.sv
// ----------------------------------------------------------------------------
// tqcs_pkg
// Shared types, constants and the vertex table of the quad setup unit.
// ----------------------------------------------------------------------------
package tqcs_pkg;

  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int VERTS_PER_QUAD      = 6;
  localparam int QUEUE_DEPTH         = 2;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_SCALE_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_SCALE_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE    = 3'd7;

  localparam logic signed [19:0] TEX_MIN = -20'sd524288;
  localparam logic signed [19:0] TEX_MAX = 20'sd524287;

  localparam logic [1:0] COL_TL = 2'd0;
  localparam logic [1:0] COL_TR = 2'd1;
  localparam logic [1:0] COL_BL = 2'd2;
  localparam logic [1:0] COL_BR = 2'd3;

  typedef struct packed {
    logic        clip_enable;
    logic [15:0] clip_left;
    logic [15:0] clip_top;
    logic [15:0] clip_right;
    logic [15:0] clip_bottom;
    logic [16:0] texel_scale_x;
    logic [16:0] texel_scale_y;
    logic        split_mode;
  } cfg_t;

  // Lanes: 0 left, 1 right, 2 top, 3 bottom. Axis 0 is x, axis 1 is y.
  typedef struct packed {
    logic [3:0][16:0] num;
    logic [1:0][16:0] sext;
    logic [1:0][15:0] dext;
    logic [3:0][15:0] src;
    logic [1:0][12:0] px;
    logic [1:0][12:0] py;
    logic [3:0][31:0] col;
  } qent_t;

  typedef struct packed {
    logic       xs;
    logic       ys;
    logic [1:0] csel;
  } vsel_t;

  function automatic vsel_t vertex_sel(input logic [2:0] idx, input logic split);
    vsel_t v;
    v = '0;
    case (idx)
      3'd0: v = '{xs: 1'b0, ys: 1'b0, csel: COL_TL};
      3'd1: v = '{xs: 1'b0, ys: 1'b1, csel: COL_BL};
      3'd2: v = '{xs: 1'b1, ys: ~split, csel: COL_BR};
      3'd3: v = '{xs: 1'b1, ys: 1'b0, csel: COL_TR};
      3'd4: v = '{xs: 1'b0, ys: split, csel: COL_TL};
      3'd5: v = '{xs: 1'b1, ys: 1'b1, csel: COL_BR};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tqcs_fifo.sv
// ----------------------------------------------------------------------------
// tqcs_fifo
// Short queue between the classifying front and the vertex back end.
// ----------------------------------------------------------------------------
module tqcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

>>> hdl/tqcs_front.sv
// ----------------------------------------------------------------------------
// tqcs_front
// Clips the destination, drops empty quads and prepares a queue entry.
// ----------------------------------------------------------------------------
module tqcs_front #(
  parameter int COORD_FRAC_BITS = tqcs_pkg::COORD_FRAC_BITS_DEF
) (
  input  tqcs_pkg::cfg_t  cfg,
  input  logic            take,
  input  logic [15:0]     dest_left,
  input  logic [15:0]     dest_top,
  input  logic [15:0]     dest_right,
  input  logic [15:0]     dest_bottom,
  input  logic [15:0]     src_left,
  input  logic [15:0]     src_top,
  input  logic [15:0]     src_right,
  input  logic [15:0]     src_bottom,
  input  logic [31:0]     colour_top_left,
  input  logic [31:0]     colour_top_right,
  input  logic [31:0]     colour_bottom_left,
  input  logic [31:0]     colour_bottom_right,
  output logic            push,
  output tqcs_pkg::qent_t entry
);

  localparam logic signed [16:0] HALF =
    (COORD_FRAC_BITS > 0) ? 17'sd1 <<< (COORD_FRAC_BITS - 1) : 17'sd0;
  localparam logic signed [16:0] POS_MIN = -17'sd4096;
  localparam logic signed [16:0] POS_MAX = 17'sd4095;

  function automatic logic [12:0] to_pixel(input logic signed [15:0] f);
    logic signed [16:0] s;
    s = ($signed({f[15], f}) + HALF) >>> COORD_FRAC_BITS;
    if (s < POS_MIN) s = POS_MIN;
    if (s > POS_MAX) s = POS_MAX;
    return s[12:0];
  endfunction

  logic signed [15:0] dl, dt, dr, db, fl, ft, fr, fb;

  always_comb begin
    dl = $signed(dest_left);
    dt = $signed(dest_top);
    dr = $signed(dest_right);
    db = $signed(dest_bottom);
    fl = dl;
    ft = dt;
    fr = dr;
    fb = db;
    if (cfg.clip_enable) begin
      if ($signed(cfg.clip_left) > dl) fl = $signed(cfg.clip_left);
      if ($signed(cfg.clip_top) > dt) ft = $signed(cfg.clip_top);
      if ($signed(cfg.clip_right) < dr) fr = $signed(cfg.clip_right);
      if ($signed(cfg.clip_bottom) < db) fb = $signed(cfg.clip_bottom);
    end
  end

  assign push = take && (fr > fl) && (fb > ft);

  always_comb begin
    entry = '0;
    entry.num[0]  = 17'($signed({fl[15], fl}) - $signed({dl[15], dl}));
    entry.num[1]  = 17'($signed({fr[15], fr}) - $signed({dr[15], dr}));
    entry.num[2]  = 17'($signed({ft[15], ft}) - $signed({dt[15], dt}));
    entry.num[3]  = 17'($signed({fb[15], fb}) - $signed({db[15], db}));
    entry.sext[0] = 17'($signed({src_right[15], src_right}) -
                        $signed({src_left[15], src_left}));
    entry.sext[1] = 17'($signed({src_bottom[15], src_bottom}) -
                        $signed({src_top[15], src_top}));
    entry.dext[0] = 16'(dest_right - dest_left);
    entry.dext[1] = 16'(dest_bottom - dest_top);
    entry.src[0]  = src_left;
    entry.src[1]  = src_right;
    entry.src[2]  = src_top;
    entry.src[3]  = src_bottom;
    entry.px[0]   = to_pixel(fl);
    entry.px[1]   = to_pixel(fr);
    entry.py[0]   = to_pixel(ft);
    entry.py[1]   = to_pixel(fb);
    entry.col[tqcs_pkg::COL_TL] = colour_top_left;
    entry.col[tqcs_pkg::COL_TR] = colour_top_right;
    entry.col[tqcs_pkg::COL_BL] = colour_bottom_left;
    entry.col[tqcs_pkg::COL_BR] = colour_bottom_right;
  end

endmodule

>>> hdl/tqcs_back.sv
// ----------------------------------------------------------------------------
// tqcs_back
// Derives the four texel edges with radix-2 dividers and emits six vertices.
// ----------------------------------------------------------------------------
module tqcs_back #(
  parameter int COORD_FRAC_BITS = tqcs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tqcs_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  tqcs_pkg::qent_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  output logic [2:0]         out_vertex_index,
  output logic [12:0]        out_pos_x,
  output logic [12:0]        out_pos_y,
  output logic [19:0]        out_tex_u,
  output logic [19:0]        out_tex_v,
  output logic [31:0]        out_vertex_colour,
  output logic               out_last
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_TEX, S_SAT, S_EMIT} state_t;

  state_t                  state_r;
  tqcs_pkg::qent_t         ent_r;
  logic [3:0][31:0]        w_r;
  logic [3:0]              neg_r;
  logic [3:0][35:0]        tprod_r;
  logic [3:0][19:0]        tex_r;
  logic [3:0]              cnt_r;
  logic [2:0]              vidx_r;

  logic [3:0][31:0]        w_nxt;
  logic [3:0][15:0]        amag, bmag;
  logic [3:0][35:0]        tprod_nxt;
  logic [3:0][19:0]        tex_nxt;
  tqcs_pkg::vsel_t         vs;

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign vs    = tqcs_pkg::vertex_sel(vidx_r, cfg.split_mode);

  always_comb begin
    logic [16:0]        t;
    logic [16:0]        d;
    logic [16:0]        nr;
    logic               ge;
    logic [16:0]        n, s;
    logic [17:0]        sq, tt;
    logic signed [35:0] sh;
    for (int k = 0; k < 4; k++) begin
      n = ent_r.num[k];
      s = ent_r.sext[k/2];
      amag[k] = n[16] ? 16'(-n) : n[15:0];
      bmag[k] = s[16] ? 16'(-s) : s[15:0];

      d  = {1'b0, ent_r.dext[k/2]};
      t  = {w_r[k][31:16], w_r[k][15]};
      ge = (t >= d);
      nr = ge ? t - d : t;
      w_nxt[k] = {nr[15:0], w_r[k][14:0], ge};

      sq = neg_r[k] ? 18'(-{2'b00, w_r[k][15:0]}) : {2'b00, w_r[k][15:0]};
      tt = 18'($signed({{2{ent_r.src[k][15]}}, ent_r.src[k]}) + $signed(sq));
      tprod_nxt[k] = 36'($signed(tt) *
                         $signed({1'b0, (k < 2) ? cfg.texel_scale_x : cfg.texel_scale_y}));

      sh = $signed(tprod_r[k]) >>> COORD_FRAC_BITS;
      if (sh < 36'(tqcs_pkg::TEX_MIN)) begin
        tex_nxt[k] = tqcs_pkg::TEX_MIN;
      end else if (sh > 36'(tqcs_pkg::TEX_MAX)) begin
        tex_nxt[k] = tqcs_pkg::TEX_MAX;
      end else begin
        tex_nxt[k] = sh[19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      vidx_r    <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            ent_r   <= q_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          for (int k = 0; k < 4; k++) begin
            w_r[k]   <= 32'(amag[k] * bmag[k]);
            neg_r[k] <= ent_r.num[k][16] ^ ent_r.sext[k/2][16];
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          w_r   <= w_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'd15) begin
            state_r <= S_TEX;
          end
        end
        S_TEX: begin
          tprod_r <= tprod_nxt;
          state_r <= S_SAT;
        end
        S_SAT: begin
          tex_r   <= tex_nxt;
          vidx_r  <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid         <= 1'b1;
          out_vertex_index  <= vidx_r;
          out_pos_x         <= ent_r.px[vs.xs];
          out_pos_y         <= ent_r.py[vs.ys];
          out_tex_u         <= tex_r[{1'b0, vs.xs}];
          out_tex_v         <= tex_r[{1'b1, vs.ys}];
          out_vertex_colour <= ent_r.col[vs.csel];
          out_last          <= (vidx_r == 3'(tqcs_pkg::VERTS_PER_QUAD - 1));
          vidx_r            <= vidx_r + 1'b1;
          if (vidx_r == 3'(tqcs_pkg::VERTS_PER_QUAD - 1)) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/textured_quad_clip_setup_unit.sv
// ----------------------------------------------------------------------------
// textured_quad_clip_setup_unit
// Scissor-clipped textured quad setup: two triangles, six vertices a quad.
// ----------------------------------------------------------------------------
//  channel  | ports                         | transfer
//  ---------+-------------------------------+-------------------------------
//  input    | start, busy, in_*             | edge with start high, busy low
//  result   | out_valid, out_*              | every cycle out_valid is high
//  config   | cfg_we, cfg_index, cfg_data   | every edge with cfg_we high
//
// A quad that survives clipping passes through the back end in order: fetch,
// multiply, the bit-serial dividers, texel scaling, saturation and emit. The
// back end works on one quad at a time; the divider loop sets the rate.
// Empty quads are dropped in the front end and cost no back end cycles.
// A two-entry queue lets the front take new quads while the back end works;
// busy is high while the queue is full. Reset is synchronous and empties
// the queue. The receiver cannot stall the result channel.
module textured_quad_clip_setup_unit #(
  parameter int COORD_FRAC_BITS = tqcs_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tqcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tqcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       in_dest_left,
  input  logic [15:0]                       in_dest_top,
  input  logic [15:0]                       in_dest_right,
  input  logic [15:0]                       in_dest_bottom,
  input  logic [15:0]                       in_src_left,
  input  logic [15:0]                       in_src_top,
  input  logic [15:0]                       in_src_right,
  input  logic [15:0]                       in_src_bottom,
  input  logic [31:0]                       in_colour_top_left,
  input  logic [31:0]                       in_colour_top_right,
  input  logic [31:0]                       in_colour_bottom_left,
  input  logic [31:0]                       in_colour_bottom_right,
  output logic                              out_valid,
  output logic [2:0]                        out_vertex_index,
  output logic [12:0]                       out_pos_x,
  output logic [12:0]                       out_pos_y,
  output logic [19:0]                       out_tex_u,
  output logic [19:0]                       out_tex_v,
  output logic [31:0]                       out_vertex_colour,
  output logic                              out_last
);

  localparam int QW = $bits(tqcs_pkg::qent_t);

  tqcs_pkg::cfg_t  cfg_r;
  tqcs_pkg::qent_t f_entry, q_data;
  logic            f_push, q_pop, q_full, q_empty;
  logic [QW-1:0]   q_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_enable   <= 1'b0;
      cfg_r.clip_left     <= 16'd0;
      cfg_r.clip_top      <= 16'd0;
      cfg_r.clip_right    <= 16'd32767;
      cfg_r.clip_bottom   <= 16'd32767;
      cfg_r.texel_scale_x <= 17'd65536;
      cfg_r.texel_scale_y <= 17'd65536;
      cfg_r.split_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tqcs_pkg::REG_CLIP_ENABLE:   cfg_r.clip_enable   <= cfg_data[0];
        tqcs_pkg::REG_CLIP_LEFT:     cfg_r.clip_left     <= cfg_data[15:0];
        tqcs_pkg::REG_CLIP_TOP:      cfg_r.clip_top      <= cfg_data[15:0];
        tqcs_pkg::REG_CLIP_RIGHT:    cfg_r.clip_right    <= cfg_data[15:0];
        tqcs_pkg::REG_CLIP_BOTTOM:   cfg_r.clip_bottom   <= cfg_data[15:0];
        tqcs_pkg::REG_TEXEL_SCALE_X: cfg_r.texel_scale_x <= cfg_data;
        tqcs_pkg::REG_TEXEL_SCALE_Y: cfg_r.texel_scale_y <= cfg_data;
        tqcs_pkg::REG_SPLIT_MODE:    cfg_r.split_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  tqcs_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .cfg                 (cfg_r),
    .take                (start && !busy),
    .dest_left           (in_dest_left),
    .dest_top            (in_dest_top),
    .dest_right          (in_dest_right),
    .dest_bottom         (in_dest_bottom),
    .src_left            (in_src_left),
    .src_top             (in_src_top),
    .src_right           (in_src_right),
    .src_bottom          (in_src_bottom),
    .colour_top_left     (in_colour_top_left),
    .colour_top_right    (in_colour_top_right),
    .colour_bottom_left  (in_colour_bottom_left),
    .colour_bottom_right (in_colour_bottom_right),
    .push                (f_push),
    .entry               (f_entry)
  );

  tqcs_fifo #(.WIDTH(QW), .DEPTH(tqcs_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_entry),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_data = q_dout;

  tqcs_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_vertex_index  (out_vertex_index),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_tex_u         (out_tex_u),
    .out_tex_v         (out_tex_v),
    .out_vertex_colour (out_vertex_colour),
    .out_last          (out_last)
  );

  a_last_on_sixth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_vertex_index == 3'd5)
    else $error("last flag away from the sixth vertex");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid &&
      out_vertex_index == ($past(out_vertex_index) + 3'd1))
    else $error("vertex run broken");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

>>> test/tb_textured_quad_clip_setup_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_textured_quad_clip_setup_unit
// Self-checking bench for the scissor-clipped textured quad setup unit. It
// sends directed and random quads under several register settings and idle
// patterns. It predicts the six vertices of every surviving quad and checks
// each emitted vertex, in order, against the prediction.
// ----------------------------------------------------------------------------
module tb_textured_quad_clip_setup_unit;

  localparam int FRAC     = tqcs_pkg::COORD_FRAC_BITS_DEF;
  localparam int CIW      = tqcs_pkg::CFG_IDX_W;
  localparam int CDW      = tqcs_pkg::CFG_DATA_W;
  localparam int WDOG_MAX = 4000;
  localparam int SETTLE   = 40;

  typedef struct {
    logic [15:0] dl, dt, dr, db, sl, st, sr, sb;
    logic [31:0] c_tl, c_tr, c_bl, c_br;
  } quad_t;

  typedef struct {
    logic [2:0]  idx;
    logic [12:0] px, py;
    logic [19:0] tu, tv;
    logic [31:0] col;
    logic        last;
  } vertex_t;

  class vertex_scoreboard;
    tqcs_pkg::cfg_t regs;
    vertex_t   vertex_q[$];
    int        errors;
    int        quads_seen;
    int        quads_drawn;
    int        vertices_checked;

    function new();
      errors = 0;
      quads_seen = 0;
      quads_drawn = 0;
      vertices_checked = 0;
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
    endtask

    function longint pixel_of(longint v);
      longint p;
      p = (v + ((1 << FRAC) / 2)) >>> FRAC;
      if (p < -4096) p = -4096;
      if (p > 4095) p = 4095;
      return p;
    endfunction

    function longint texel_of(longint se, longint fin, longint dst, longint sext,
                              longint dext, longint scale);
      longint t;
      t = se + ((fin - dst) * sext) / dext;
      t = (t * scale) >>> FRAC;
      if (t < -524288) t = -524288;
      if (t > 524287) t = 524287;
      return t;
    endfunction

    function void note_quad(quad_t q);
      longint dl, dt, dr, db, sl, st, sr, sb, fl, ft, fr, fb;
      longint px[2], py[2], tu[2], tv[2];
      bit xs, ys;
      logic [31:0] col;
      vertex_t v;
      dl = longint'($signed(q.dl)); dt = longint'($signed(q.dt));
      dr = longint'($signed(q.dr)); db = longint'($signed(q.db));
      sl = longint'($signed(q.sl)); st = longint'($signed(q.st));
      sr = longint'($signed(q.sr)); sb = longint'($signed(q.sb));
      fl = dl; ft = dt; fr = dr; fb = db;
      quads_seen++;
      if (regs.clip_enable) begin
        if (longint'($signed(regs.clip_left)) > fl) fl = longint'($signed(regs.clip_left));
        if (longint'($signed(regs.clip_top)) > ft) ft = longint'($signed(regs.clip_top));
        if (longint'($signed(regs.clip_right)) < fr) fr = longint'($signed(regs.clip_right));
        if (longint'($signed(regs.clip_bottom)) < fb) begin
          fb = longint'($signed(regs.clip_bottom));
        end
      end
      if (fr <= fl || fb <= ft) return;
      quads_drawn++;
      tu[0] = texel_of(sl, fl, dl, sr - sl, dr - dl, longint'(regs.texel_scale_x));
      tu[1] = texel_of(sr, fr, dr, sr - sl, dr - dl, longint'(regs.texel_scale_x));
      tv[0] = texel_of(st, ft, dt, sb - st, db - dt, longint'(regs.texel_scale_y));
      tv[1] = texel_of(sb, fb, db, sb - st, db - dt, longint'(regs.texel_scale_y));
      px[0] = pixel_of(fl); px[1] = pixel_of(fr);
      py[0] = pixel_of(ft); py[1] = pixel_of(fb);
      for (int k = 0; k < tqcs_pkg::VERTS_PER_QUAD; k++) begin
        case (k)
          0: begin xs = 1'b0; ys = 1'b0; col = q.c_tl; end
          1: begin xs = 1'b0; ys = 1'b1; col = q.c_bl; end
          2: begin xs = 1'b1; ys = !regs.split_mode; col = q.c_br; end
          3: begin xs = 1'b1; ys = 1'b0; col = q.c_tr; end
          4: begin xs = 1'b0; ys = regs.split_mode; col = q.c_tl; end
          default: begin xs = 1'b1; ys = 1'b1; col = q.c_br; end
        endcase
        v.idx = k[2:0];
        v.px = px[xs][12:0];
        v.py = py[ys][12:0];
        v.tu = tu[xs][19:0];
        v.tv = tv[ys][19:0];
        v.col = col;
        v.last = (k == tqcs_pkg::VERTS_PER_QUAD - 1);
        vertex_q.push_back(v);
      end
    endfunction

    task check_vertex(vertex_t got);
      vertex_t want;
      if (vertex_q.size() == 0) begin
        report("unexpected vertex", 32'(got.idx), 32'd0);
        return;
      end
      want = vertex_q.pop_front();
      vertices_checked++;
      if (got.idx !== want.idx) report("vertex_index", 32'(got.idx), 32'(want.idx));
      if (got.px !== want.px) report("pos_x", 32'(got.px), 32'(want.px));
      if (got.py !== want.py) report("pos_y", 32'(got.py), 32'(want.py));
      if (got.tu !== want.tu) report("tex_u", 32'(got.tu), 32'(want.tu));
      if (got.tv !== want.tv) report("tex_v", 32'(got.tv), 32'(want.tv));
      if (got.col !== want.col) report("vertex_colour", got.col, want.col);
      if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic clk, rst_n, cfg_we, start, busy, out_valid, out_last;
  logic [CIW-1:0] cfg_index;
  logic [CDW-1:0] cfg_data;
  quad_t drv;
  logic [2:0] out_vertex_index;
  logic [12:0] out_pos_x, out_pos_y;
  logic [19:0] out_tex_u, out_tex_v;
  logic [31:0] out_vertex_colour;

  vertex_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  textured_quad_clip_setup_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .in_dest_left(drv.dl), .in_dest_top(drv.dt),
    .in_dest_right(drv.dr), .in_dest_bottom(drv.db),
    .in_src_left(drv.sl), .in_src_top(drv.st),
    .in_src_right(drv.sr), .in_src_bottom(drv.sb),
    .in_colour_top_left(drv.c_tl), .in_colour_top_right(drv.c_tr),
    .in_colour_bottom_left(drv.c_bl), .in_colour_bottom_right(drv.c_br),
    .out_valid(out_valid), .out_vertex_index(out_vertex_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .out_vertex_colour(out_vertex_colour), .out_last(out_last)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    vertex_t v;
    if (rst_n) begin
      if (start && !busy) sb.note_quad(drv);
      if (out_valid) begin
        v.idx = out_vertex_index; v.px = out_pos_x; v.py = out_pos_y;
        v.tu = out_tex_u; v.tv = out_tex_v; v.col = out_vertex_colour;
        v.last = out_last;
        sb.check_vertex(v);
      end
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("watchdog expired at %0t", $time);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task apply_regs(input tqcs_pkg::cfg_t c);
    logic [CDW-1:0] vals[8];
    vals[tqcs_pkg::REG_CLIP_ENABLE] = CDW'(c.clip_enable);
    vals[tqcs_pkg::REG_CLIP_LEFT] = CDW'(c.clip_left);
    vals[tqcs_pkg::REG_CLIP_TOP] = CDW'(c.clip_top);
    vals[tqcs_pkg::REG_CLIP_RIGHT] = CDW'(c.clip_right);
    vals[tqcs_pkg::REG_CLIP_BOTTOM] = CDW'(c.clip_bottom);
    vals[tqcs_pkg::REG_TEXEL_SCALE_X] = c.texel_scale_x;
    vals[tqcs_pkg::REG_TEXEL_SCALE_Y] = c.texel_scale_y;
    vals[tqcs_pkg::REG_SPLIT_MODE] = CDW'(c.split_mode);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[CIW-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sb.regs = c;
  endtask

  task drain;
    while (sb.vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task send_quad(input quad_t q);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task stop_sending;
    start <= 1'b0;
    @(posedge clk);
  endtask

  function quad_t make_quad(int l, int t, int r, int b, int sl, int st, int sr, int sb_);
    quad_t q;
    q.dl = 16'(l); q.dt = 16'(t); q.dr = 16'(r); q.db = 16'(b);
    q.sl = 16'(sl); q.st = 16'(st); q.sr = 16'(sr); q.sb = 16'(sb_);
    q.c_tl = $urandom; q.c_tr = $urandom; q.c_bl = $urandom; q.c_br = $urandom;
    return q;
  endfunction

  function int edge_pair_end(int lo, int span);
    return (lo + span > 32767) ? 32767 : lo + span;
  endfunction

  function quad_t random_quad();
    quad_t q;
    int l, t, sl, st;
    if ($urandom_range(99) < 15) begin
      q = make_quad($urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
    end else begin
      l = $urandom_range(8000) - 4000;
      t = $urandom_range(8000) - 4000;
      sl = $urandom_range(8000) - 4000;
      st = $urandom_range(8000) - 4000;
      q = make_quad(l, t, edge_pair_end(l, $urandom_range(1, 3000)),
                    edge_pair_end(t, $urandom_range(1, 3000)),
                    sl, st, sl + $urandom_range(4000) - 800, st + $urandom_range(4000) - 800);
    end
    return q;
  endfunction

  function tqcs_pkg::cfg_t random_regs();
    tqcs_pkg::cfg_t c;
    int l, t;
    l = $urandom_range(6000) - 3000;
    t = $urandom_range(6000) - 3000;
    c.clip_enable = $urandom_range(3) != 0;
    c.clip_left = 16'(l);
    c.clip_top = 16'(t);
    c.clip_right = ($urandom_range(9) == 0) ? 16'(l - int'($urandom_range(200))) :
                   16'(edge_pair_end(l, $urandom_range(6000)));
    c.clip_bottom = 16'(edge_pair_end(t, $urandom_range(6000)));
    case ($urandom_range(3))
      0: c.texel_scale_x = 17'd0;
      1: c.texel_scale_x = 17'h1FFFF;
      default: c.texel_scale_x = 17'($urandom);
    endcase
    c.texel_scale_y = ($urandom_range(3) == 0) ? 17'h1FFFF : 17'($urandom);
    c.split_mode = 1'($urandom);
    return c;
  endfunction

  initial begin
    tqcs_pkg::cfg_t c;
    int phase_idle[4];
    phase_idle = '{0, 73, 0, 12};
    sb = new();
    sb.regs = '{1'b0, 16'd0, 16'd0, 16'd32767, 16'd32767, 17'd65536, 17'd65536, 1'b0};
    rst_n = 0; start = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    drv = make_quad(0, 0, 0, 0, 0, 0, 0, 0);
    quiet_cycles = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: plain, zero-area, inverted, mirrored and extreme quads.
    send_quad(make_quad(16, 32, 800, 640, 0, 0, 256, 256));
    send_quad(make_quad(100, 100, 100, 400, 0, 0, 256, 256));
    send_quad(make_quad(100, 400, 900, 100, 0, 0, 256, 256));
    send_quad(make_quad(-40, -40, 200, 300, 512, 512, 0, 0));
    send_quad(make_quad(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_quad(make_quad(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
    send_quad(make_quad(7, 8, 9, 24, 1, 2, 3, 4));
    send_quad(make_quad(32766, 32766, 32767, 32767, 0, 0, 16, 16));
    send_quad(make_quad(-32768, -32768, -32767, -32767, 0, 0, 16, 16));
    stop_sending();
    drain();

    c = '{1'b1, 16'd80, 16'd80, 16'd1600, 16'd1200, 17'h1FFFF, 17'd0, 1'b1};
    apply_regs(c);
    send_quad(make_quad(0, 0, 3200, 3200, 0, 0, 1024, 1024));
    send_quad(make_quad(200, 200, 400, 400, 100, 100, -100, -100));
    send_quad(make_quad(2000, 0, 3000, 500, 0, 0, 16, 16));
    send_quad(make_quad(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_quad(make_quad(1600, 80, 2000, 400, 0, 0, 16, 16));
    stop_sending();
    drain();

    c = '{1'b1, 16'd500, 16'd0, 16'd500, 16'd900, 17'd65536, 17'd65536, 1'b0};
    apply_regs(c);
    send_quad(make_quad(0, 0, 1000, 1000, 0, 0, 256, 256));
    c.clip_right = 16'd1000;
    c.clip_bottom = 16'hFF00;
    stop_sending();
    drain();
    apply_regs(c);
    send_quad(make_quad(0, 0, 1000, 1000, 0, 0, 256, 256));
    stop_sending();
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      apply_regs(random_regs());
      for (int i = 0; i < 100; i++) begin
        send_quad(random_quad());
        if (p == 1 && i == 50) begin
          start <= 1'b0;
          @(posedge clk);
          while (sb.vertex_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
      stop_sending();
      drain();
    end

    $display("Sent %0d quads over reset, clipping, empty-scissor and random settings.",
             sb.quads_seen);
    $display("%0d quads drawn, %0d vertices checked, %0d mismatches.",
             sb.quads_drawn, sb.vertices_checked, sb.errors);
    if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
